@@ hw/rtl/u8fd_pkg.sv @@
// Shared types and constants for the filtering UTF-8 decoder.
package u8fd_pkg;

   // Smallest lead byte that can start a multi-byte sequence.
   localparam logic [7:0] LEAD_MIN     = 8'hC2;
   // Lead bytes whose second byte must clear a floor to avoid overlong forms.
   localparam logic [7:0] LEAD_3_ZERO  = 8'hE0;
   localparam logic [7:0] LEAD_4_ZERO  = 8'hF0;
   localparam logic [7:0] LEAD_5_ZERO  = 8'hF8;
   localparam logic [7:0] LEAD_6_ZERO  = 8'hFC;
   localparam logic [7:0] SECOND_3_MIN = 8'hA0;
   localparam logic [7:0] SECOND_4_MIN = 8'h90;
   localparam logic [7:0] SECOND_5_MIN = 8'h88;
   localparam logic [7:0] SECOND_6_MIN = 8'h84;
   // First byte value that is never valid as a lead.
   localparam logic [7:0] LEAD_BAD     = 8'hFE;

   localparam int unsigned CODE_W  = 31;
   localparam int unsigned COUNT_W = 32;
   localparam int unsigned LEN_W   = 3;
   // Packed result word: 1 + 31 + 3 + 32 + 32 = 99 bits, padded to 13 bytes.
   localparam int unsigned RSP_RAW_W  = 1 + CODE_W + LEN_W + 2 * COUNT_W;
   localparam int unsigned RSP_DATA_W = ((RSP_RAW_W + 7) / 8) * 8;

   // One decoded result, as it leaves the decode stage.
   typedef struct packed {
      logic               char_valid;
      logic [CODE_W-1:0]  code_point;
      logic [LEN_W-1:0]   char_bytes;
      logic [COUNT_W-1:0] char_count;
      logic [COUNT_W-1:0] kept_bytes;
      logic               end_of_string;
   } result_type;

endpackage

@@ hw/rtl/utf8_filtering_decoder.sv @@
// Each accepted byte is held in the input register, then decoded into the result register once that is free.
// Throughput: one byte per cycle while rsp_tready is high; one result word for every byte accepted.
// The decode of one byte is a single pass between the input register and the
// result register, with the sequence state updated as the byte moves on.
// Reset (synchronous, active high) empties both registers, clears any open
// sequence and sets both running counts to zero.
module utf8_filtering_decoder
   import u8fd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,  // [7:0] data_byte
   input  logic                  req_tlast,  // last_byte
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [0] char_valid, [31:1] code_point, [34:32] char_bytes,
   // [66:35] char_count, [98:67] kept_bytes, rest zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast   // end_of_string
);

   logic       held_valid;
   logic [7:0] held_byte;
   logic       held_last;
   logic       out_free;
   logic       step;
   result_type dec_result;
   result_type out_result;

   // A held byte is decoded when the result register can take its word.
   assign step = held_valid && out_free;

   u8fd_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_byte    (req_tdata),
      .in_last    (req_tlast),
      .take       (step),
      .held_valid (held_valid),
      .held_byte  (held_byte),
      .held_last  (held_last)
   );

   u8fd_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .data_byte (held_byte),
      .last_byte (held_last),
      .result    (dec_result)
   );

   u8fd_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (step),
      .free       (out_free),
      .result     (dec_result),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (out_result)
   );

   // Pack the result word, first field in the lowest bits.
   assign rsp_tdata = RSP_DATA_W'({out_result.kept_bytes,
                                   out_result.char_count,
                                   out_result.char_bytes,
                                   out_result.code_point,
                                   out_result.char_valid});
   assign rsp_tlast = out_result.end_of_string;

endmodule

@@ hw/rtl/u8fd_in_reg.sv @@
// Input register stage holding one received byte until decode takes it.
module u8fd_in_reg
   import u8fd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  logic [7:0] in_byte,
   input  logic       in_last,
   input  logic       take,
   output logic       held_valid,
   output logic [7:0] held_byte,
   output logic       held_last
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       last_ff;

   // A new word may enter when the stage is empty or is emptied this cycle.
   assign in_ready = !valid_ff || take;
   assign valid_in = in_valid ? 1'b1 : (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload is captured on acceptance only.
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         byte_ff <= in_byte;
         last_ff <= in_last;
      end
   end

   assign held_valid = valid_ff;
   assign held_byte  = byte_ff;
   assign held_last  = last_ff;

endmodule

@@ hw/rtl/u8fd_decode.sv @@
// Sequence state, counters and the single-pass decode of one byte.
module u8fd_decode
   import u8fd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] data_byte,
   input  logic       last_byte,
   output result_type result
);

   logic [7:0]         lead_ff, lead_in;
   logic [LEN_W-1:0]   expected_ff, expected_in;
   logic [LEN_W-1:0]   seen_ff, seen_in;
   logic [CODE_W-1:0]  partial_ff, partial_in;
   logic [COUNT_W-1:0] chars_ff, chars_in;
   logic [COUNT_W-1:0] bytes_ff, bytes_in;

   logic               is_cont;
   logic               overlong;
   logic               taken;
   logic [LEN_W-1:0]   seen_inc;
   logic [CODE_W-1:0]  code_shifted;
   logic [LEN_W-1:0]   lead_len;
   logic [CODE_W-1:0]  lead_bits;
   logic               char_valid;
   logic [CODE_W-1:0]  code;
   logic [LEN_W-1:0]   nbytes;
   logic [COUNT_W:0]   bytes_sum;

   // Continuation test and the overlong check on the second byte.
   always_comb begin
      is_cont  = (data_byte[7:6] == 2'b10);
      overlong = (seen_ff == LEN_W'(1)) &&
                 (((lead_ff == LEAD_3_ZERO) && (data_byte < SECOND_3_MIN)) ||
                  ((lead_ff == LEAD_4_ZERO) && (data_byte < SECOND_4_MIN)) ||
                  ((lead_ff == LEAD_5_ZERO) && (data_byte < SECOND_5_MIN)) ||
                  ((lead_ff == LEAD_6_ZERO) && (data_byte < SECOND_6_MIN)));
      taken        = (expected_ff != '0) && is_cont && !overlong;
      seen_inc     = seen_ff + LEN_W'(1);
      code_shifted = {partial_ff[CODE_W-7:0], data_byte[5:0]};
   end

   // Classify the byte as a possible lead.
   always_comb begin
      lead_len  = '0;
      lead_bits = '0;
      if (data_byte >= LEAD_MIN && data_byte < LEAD_3_ZERO) begin
         lead_len  = LEN_W'(2);
         lead_bits = CODE_W'(data_byte[4:0]);
      end else if (data_byte >= LEAD_3_ZERO && data_byte < LEAD_4_ZERO) begin
         lead_len  = LEN_W'(3);
         lead_bits = CODE_W'(data_byte[3:0]);
      end else if (data_byte >= LEAD_4_ZERO && data_byte < LEAD_5_ZERO) begin
         lead_len  = LEN_W'(4);
         lead_bits = CODE_W'(data_byte[2:0]);
      end else if (data_byte >= LEAD_5_ZERO && data_byte < LEAD_6_ZERO) begin
         lead_len  = LEN_W'(5);
         lead_bits = CODE_W'(data_byte[1:0]);
      end else if (data_byte >= LEAD_6_ZERO && data_byte < LEAD_BAD) begin
         lead_len  = LEN_W'(6);
         lead_bits = CODE_W'(data_byte[0]);
      end
   end

   // Next sequence state and the character completed by this byte.
   always_comb begin
      lead_in     = lead_ff;
      expected_in = expected_ff;
      seen_in     = seen_ff;
      partial_in  = partial_ff;
      char_valid  = 1'b0;
      code        = '0;
      nbytes      = '0;
      if (taken) begin
         if (seen_inc >= expected_ff) begin
            char_valid  = 1'b1;
            code        = code_shifted;
            nbytes      = expected_ff;
            expected_in = '0;
            seen_in     = '0;
            partial_in  = '0;
         end else begin
            seen_in    = seen_inc;
            partial_in = code_shifted;
         end
      end else begin
         // A broken sequence is dropped and the byte is tried as a new start.
         expected_in = '0;
         seen_in     = '0;
         partial_in  = '0;
         if (!data_byte[7]) begin
            char_valid = 1'b1;
            code       = CODE_W'(data_byte);
            nbytes     = LEN_W'(1);
         end else if (lead_len != '0) begin
            lead_in     = data_byte;
            expected_in = lead_len;
            seen_in     = LEN_W'(1);
            partial_in  = lead_bits;
         end
      end
      // A sequence still open at the end of the string is discarded.
      if (last_byte && expected_in != '0) begin
         expected_in = '0;
         seen_in     = '0;
         partial_in  = '0;
      end
   end

   // Saturating counters.
   always_comb begin
      chars_in  = chars_ff;
      bytes_in  = bytes_ff;
      bytes_sum = {1'b0, bytes_ff} + (COUNT_W+1)'(nbytes);
      if (char_valid) begin
         if (chars_ff != '1) begin
            chars_in = chars_ff + COUNT_W'(1);
         end
         bytes_in = bytes_sum[COUNT_W] ? '1 : bytes_sum[COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lead_ff     <= '0;
         expected_ff <= '0;
         seen_ff     <= '0;
         partial_ff  <= '0;
         chars_ff    <= '0;
         bytes_ff    <= '0;
      end else if (step) begin
         lead_ff     <= lead_in;
         expected_ff <= expected_in;
         seen_ff     <= seen_in;
         partial_ff  <= partial_in;
         chars_ff    <= chars_in;
         bytes_ff    <= bytes_in;
      end
   end

   always_comb begin
      result.char_valid    = char_valid;
      result.code_point    = code;
      result.char_bytes    = nbytes;
      result.char_count    = chars_in;
      result.kept_bytes    = bytes_in;
      result.end_of_string = last_byte;
   end

endmodule

@@ hw/rtl/u8fd_out_reg.sv @@
// Result register holding one decoded word until the sink takes it.
module u8fd_out_reg
   import u8fd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   output logic       free,
   input  result_type result,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_result
);

   logic       valid_ff, valid_in;
   result_type result_ff;

   // The register can load when it is empty or its word leaves this cycle.
   assign free     = !valid_ff || out_ready;
   assign valid_in = load ? 1'b1 : (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign out_valid  = valid_ff;
   assign out_result = result_ff;

endmodule
